>>> rtl/core/acss_pkg.sv
// Package for the ADC channel scan sequencer: item structs, action codes and constants.
// No dependencies; every module of the sequencer imports it.
package acss_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CH_IDX_W = 3;
	localparam int PCT_W    = 8;

	localparam logic [1:0] ACT_UPDATE     = 2'd0;
	localparam logic [1:0] ACT_ACTIVATE   = 2'd1;
	localparam logic [1:0] ACT_DEACTIVATE = 2'd2;
	localparam logic [1:0] ACT_READ       = 2'd3;

	localparam logic [PCT_W-1:0] NEVER_READ  = 8'd255;
	localparam logic [PCT_W-1:0] PERCENT_MAX = 8'd100;

	typedef struct packed {
		logic [1:0]          action;
		logic [CH_IDX_W-1:0] channel_index;
		logic                converter_busy;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic                start_conversion;
		logic [CH_IDX_W-1:0] scan_channel;
		logic [PCT_W-1:0]    read_value;
	} out_item_t;

endpackage

>>> rtl/core/acss_scaler.sv
// Scales a raw sample to a percentage of full scale, capped at 100.
// Depends on acss_pkg.
module acss_scaler import acss_pkg::*; #(
	parameter int FULL_SCALE = 1023
) (
	input  logic [SAMPLE_W-1:0] sample,
	output logic [PCT_W-1:0]    percent
);

	// Reciprocal multiply: 2^SHIFT exceeds 1024 * FULL_SCALE, so the rounded-up
	// reciprocal gives the exact truncated quotient for every 10-bit sample.
	localparam int SHIFT   = SAMPLE_W + 1 + $clog2(FULL_SCALE);
	localparam int RECIP_W = 19;
	localparam int PROD_W  = SAMPLE_W + RECIP_W;
	localparam logic [63:0] RECIP =
		((64'(PERCENT_MAX) << SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;

	assign prod    = PROD_W'(sample) * PROD_W'(RECIP[RECIP_W-1:0]);
	assign quot    = prod >> SHIFT;
	assign percent = (quot > PROD_W'(PERCENT_MAX)) ? PERCENT_MAX : quot[PCT_W-1:0];

endmodule

>>> rtl/core/acss_rr_pick.sv
// Rotating priority pick: the next enabled channel after a given one.
// Depends on acss_pkg.
module acss_rr_pick import acss_pkg::*; #(
	parameter int CHANNELS = 8,
	localparam int CW = $clog2(CHANNELS)
) (
	input  logic [CHANNELS-1:0] enables,
	input  logic [CW-1:0]       from,
	output logic [CW-1:0]       next
);

	logic [2*CHANNELS-1:0] dbl;
	logic [CHANNELS-1:0]   rot;
	logic [CW:0]           start;
	logic [CW:0]           first;
	logic [CW:0]           sum;
	logic                  found;

	always_comb begin
		start = (CW+1)'(from) + (CW+1)'(1);
		dbl   = {enables, enables};
		// Bit i of rot is the enable of channel from+1+i, wrapped.
		rot   = CHANNELS'(dbl >> start);
		first = '0;
		found = 1'b0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (rot[i]) begin
				first = (CW+1)'(i);
				found = 1'b1;
			end
		end
		sum = start + first;
		if (sum >= (CW+1)'(CHANNELS)) begin
			sum = sum - (CW+1)'(CHANNELS);
		end
		next = found ? sum[CW-1:0] : from;
	end

endmodule

>>> rtl/core/adc_channel_scan_sequencer_core.sv
// Top level of the ADC channel scan sequencer: input register, channel state, result register.
// Depends on acss_pkg, acss_scaler and acss_rr_pick.
//
// Channel  Handshake            Payload
// in       in_valid / in_ready  in_item   (action, channel_index, converter_busy, sample)
// out      out_valid / out_ready out_item (start_conversion, scan_channel, read_value)
//
// One item per cycle while the output is not stalled by out_ready; each item passes
// through the input register and then the result register before its result appears.
// Reset clears all enable flags, sets every stored percentage to 255 and the
// current channel to zero.
// With out_ready low the result holds; one more item waits in the input register
// and in_ready drops once both are full.
module adc_channel_scan_sequencer_core import acss_pkg::*; #(
	parameter int CHANNELS   = 8,
	parameter int FULL_SCALE = 1023
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int CW = $clog2(CHANNELS);

	in_item_t          item_s1;
	logic              valid_s1;
	out_item_t         item_s2;
	logic              valid_s2;

	logic [CHANNELS-1:0] en_q;
	logic [PCT_W-1:0]    pct_q [CHANNELS];
	logic [CW-1:0]       cur_q;

	logic                advance;
	logic                any_en;
	logic                ch_ok;
	logic [CW-1:0]       ch_idx;
	logic [CW-1:0]       pick;
	logic [PCT_W-1:0]    scaled;
	logic [CHANNELS-1:0] en_d;
	logic [CW-1:0]       cur_d;
	logic                wr_pct;
	logic                start_c;
	logic [PCT_W-1:0]    rd_c;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	acss_scaler #(
		.FULL_SCALE(FULL_SCALE)
	) u_scaler (
		.sample (item_s1.sample),
		.percent(scaled)
	);

	acss_rr_pick #(
		.CHANNELS(CHANNELS)
	) u_pick (
		.enables(en_q),
		.from   (cur_q),
		.next   (pick)
	);

	always_comb begin
		any_en  = |en_q;
		ch_ok   = int'(item_s1.channel_index) < CHANNELS;
		ch_idx  = CW'(item_s1.channel_index);
		en_d    = en_q;
		cur_d   = cur_q;
		wr_pct  = 1'b0;
		start_c = 1'b0;
		rd_c    = '0;
		unique case (item_s1.action)
			ACT_UPDATE: begin
				// The current channel is written even if it was disabled meanwhile.
				if (!item_s1.converter_busy && any_en) begin
					wr_pct  = 1'b1;
					cur_d   = pick;
					start_c = 1'b1;
				end
			end
			ACT_ACTIVATE: begin
				if (ch_ok) begin
					if (!any_en) begin
						cur_d = ch_idx;
					end
					en_d[ch_idx] = 1'b1;
				end
			end
			ACT_DEACTIVATE: begin
				if (ch_ok) begin
					en_d[ch_idx] = 1'b0;
				end
			end
			ACT_READ: begin
				rd_c = ch_ok ? pct_q[ch_idx] : NEVER_READ;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			en_q     <= '0;
			cur_q    <= '0;
			pct_q    <= '{default: NEVER_READ};
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				en_q     <= en_d;
				cur_q    <= cur_d;
				if (wr_pct) begin
					pct_q[cur_q] <= scaled;
				end
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// The input register is cleared so the action decode never sees unknown bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2.start_conversion <= start_c;
			item_s2.scan_channel     <= CH_IDX_W'(cur_d);
			item_s2.read_value       <= rd_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	a_start_on_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		advance && start_c |=> en_q[cur_q])
		else $error("scan moved to a channel that is not enabled");

	a_start_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.start_conversion |-> out_item.read_value == '0)
		else $error("conversion start carries a read value");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.read_value != NEVER_READ |-> out_item.read_value <= PERCENT_MAX)
		else $error("read value above full scale");

endmodule
